// File: rtl/core/ock_pkg.sv
// ----------------------------------------------------------------------------
// ock_pkg
// Shared types, codes and helper functions for the oven cook controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ock_pkg;

    // event codes
    localparam logic [2:0] CMD_HALF_TICK   = 3'd0;
    localparam logic [2:0] CMD_PRESS_TICK  = 3'd1;
    localparam logic [2:0] CMD_KNOB        = 3'd2;
    localparam logic [2:0] CMD_SELECT_DOWN = 3'd3;
    localparam logic [2:0] CMD_SELECT_UP   = 3'd4;
    localparam logic [2:0] CMD_START_DOWN  = 3'd5;
    localparam logic [2:0] CMD_START_UP    = 3'd6;

    // cook modes
    localparam logic [1:0] MODE_BAKE  = 2'd0;
    localparam logic [1:0] MODE_TOAST = 2'd1;
    localparam logic [1:0] MODE_BROIL = 2'd2;

    // phase codes reported on the result
    localparam logic [1:0] PHASE_SETUP  = 2'd0;
    localparam logic [1:0] PHASE_COOK   = 2'd1;
    localparam logic [1:0] PHASE_CANCEL = 2'd2;
    localparam logic [1:0] PHASE_SELECT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_HOLD_TICKS = 2'd0;
    localparam logic [1:0] CFG_BAKE_TEMP  = 2'd1;
    localparam logic [1:0] CFG_BROIL_TEMP = 2'd2;

    // configuration reset values
    localparam logic [4:0] HOLD_TICKS_RESET = 5'd5;
    localparam logic [9:0] BAKE_TEMP_RESET  = 10'd350;
    localparam logic [9:0] BROIL_TEMP_RESET = 10'd500;

    localparam logic [9:0] KNOB_OFFSET = 10'd300;
    localparam logic [4:0] PRESS_MAX   = 5'd31;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] knob_value;
    } item_t;

    typedef struct packed {
        logic [4:0] hold_ticks;
        logic [9:0] bake_default_temp;
        logic [9:0] broil_temp;
    } cfg_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] mode;
        logic       adjusting_temp;
        logic [2:0] minutes;
        logic [5:0] seconds;
        logic [9:0] temperature;
        logic       top_heater;
        logic       bottom_heater;
        logic [7:0] leds;
    } result_t;

    typedef struct packed {
        logic [2:0] minutes;
        logic [5:0] seconds;
    } mmss_t;

    // split 0..255 seconds into minutes and seconds by constant compares
    function automatic mmss_t split_secs(input logic [7:0] s);
        mmss_t r;
        if (s >= 8'd240)
        begin
            r.minutes = 3'd4;
            r.seconds = 6'(s - 8'd240);
        end
        else if (s >= 8'd180)
        begin
            r.minutes = 3'd3;
            r.seconds = 6'(s - 8'd180);
        end
        else if (s >= 8'd120)
        begin
            r.minutes = 3'd2;
            r.seconds = 6'(s - 8'd120);
        end
        else if (s >= 8'd60)
        begin
            r.minutes = 3'd1;
            r.seconds = 6'(s - 8'd60);
        end
        else
        begin
            r.minutes = 3'd0;
            r.seconds = s[5:0];
        end
        return r;
    endfunction

    // progress bar: bit i lit (i >= 1) when 8*r exceeds i*t, bit 0 lit; all dark if r or t is 0
    function automatic logic [7:0] bar_of(input logic [8:0] r, input logic [8:0] t);
        logic [7:0]  bar;
        logic [11:0] r8;
        r8  = {r, 3'b000};
        bar = 8'h01;
        for (int i = 1; i < 8; i++)
        begin
            bar[i] = r8 > 12'({3'b000, t} * 12'(i));
        end
        if (r == 9'd0 || t == 9'd0)
        begin
            bar = 8'h00;
        end
        return bar;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ock_cfg_regs.sv
// ----------------------------------------------------------------------------
// ock_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module ock_cfg_regs
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [9:0]   cfg_data,
    output ock_pkg::cfg_t     cfg
);

    ock_pkg::cfg_t cfg_reg;
    ock_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ock_pkg::CFG_HOLD_TICKS: cfg_next.hold_ticks        = cfg_data[4:0];
                ock_pkg::CFG_BAKE_TEMP:  cfg_next.bake_default_temp = cfg_data;
                ock_pkg::CFG_BROIL_TEMP: cfg_next.broil_temp        = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks        <= ock_pkg::HOLD_TICKS_RESET;
            cfg_reg.bake_default_temp <= ock_pkg::BAKE_TEMP_RESET;
            cfg_reg.broil_temp        <= ock_pkg::BROIL_TEMP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/ock_ctrl.sv
// ----------------------------------------------------------------------------
// ock_ctrl
// Controller state and the single-pass event logic that updates it.
// ----------------------------------------------------------------------------
`default_nettype none

module ock_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  ock_pkg::item_t      item,
    input  ock_pkg::cfg_t       cfg,
    output ock_pkg::result_t    result
);

    typedef enum logic [3:0] {
        ST_SETUP  = 4'b0001,
        ST_COOK   = 4'b0010,
        ST_CANCEL = 4'b0100,
        ST_SELECT = 4'b1000
    } state_t;

    state_t        state_reg,         state_next;
    logic [1:0]    mode_reg,          mode_next;
    logic          temp_sel_reg,      temp_sel_next;
    logic [2:0]    set_min_reg,       set_min_next;
    logic [5:0]    set_sec_reg,       set_sec_next;
    logic [9:0]    set_temp_reg,      set_temp_next;
    logic [8:0]    total_reg,         total_next;
    logic [8:0]    remain_reg,        remain_next;
    logic [4:0]    press_reg,         press_next;
    logic          heating_reg,       heating_next;
    logic [7:0]    led_reg,           led_next;

    ock_pkg::mmss_t knob_split;
    ock_pkg::mmss_t remain_split;
    logic [8:0]     remain_dec;
    logic [4:0]     press_inc;
    logic [8:0]     set_total_secs;
    logic [1:0]     phase;

    assign knob_split     = ock_pkg::split_secs(item.knob_value);
    assign remain_dec     = remain_reg - 9'd1;
    assign remain_split   = ock_pkg::split_secs(remain_dec[8:1]);
    assign press_inc      = (press_reg < ock_pkg::PRESS_MAX) ? press_reg + 5'd1 : press_reg;
    assign set_total_secs = 9'(9'(set_min_reg) * 9'd60 + 9'(set_sec_reg));

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        temp_sel_next = temp_sel_reg;
        set_min_next  = set_min_reg;
        set_sec_next  = set_sec_reg;
        set_temp_next = set_temp_reg;
        total_next    = total_reg;
        remain_next   = remain_reg;
        press_next    = press_reg;
        heating_next  = heating_reg;
        led_next      = led_reg;

        case (item.cmd)
            ock_pkg::CMD_HALF_TICK:
            begin
                if (heating_reg && remain_reg != 9'd0)
                begin
                    remain_next = remain_dec;
                    if (!remain_dec[0])
                    begin
                        set_min_next = remain_split.minutes;
                        set_sec_next = remain_split.seconds;
                    end
                    if (remain_dec == 9'd0)
                    begin
                        // finished: back to setup
                        heating_next  = 1'b0;
                        led_next      = 8'h00;
                        temp_sel_next = 1'b0;
                        state_next    = ST_SETUP;
                        if (mode_reg == ock_pkg::MODE_BAKE)
                        begin
                            set_temp_next = cfg.bake_default_temp;
                        end
                    end
                    else
                    begin
                        led_next = ock_pkg::bar_of(remain_dec, total_reg);
                    end
                end
            end
            ock_pkg::CMD_PRESS_TICK:
            begin
                press_next = press_inc;
                if (press_inc >= cfg.hold_ticks)
                begin
                    if (state_reg == ST_SELECT)
                    begin
                        if (mode_reg == ock_pkg::MODE_BAKE)
                        begin
                            temp_sel_next = ~temp_sel_reg;
                        end
                        state_next = ST_SETUP;
                    end
                    else if (state_reg == ST_CANCEL)
                    begin
                        heating_next  = 1'b0;
                        led_next      = 8'h00;
                        temp_sel_next = 1'b0;
                        state_next    = ST_SETUP;
                        if (mode_reg == ock_pkg::MODE_BAKE)
                        begin
                            set_temp_next = cfg.bake_default_temp;
                        end
                    end
                end
            end
            ock_pkg::CMD_KNOB:
            begin
                if (state_reg == ST_SETUP)
                begin
                    if (temp_sel_reg)
                    begin
                        set_temp_next = {2'b00, item.knob_value} + ock_pkg::KNOB_OFFSET;
                    end
                    else
                    begin
                        set_min_next = knob_split.minutes;
                        set_sec_next = knob_split.seconds;
                    end
                end
            end
            ock_pkg::CMD_SELECT_DOWN:
            begin
                if (state_reg == ST_SETUP)
                begin
                    press_next = 5'd0;
                    state_next = ST_SELECT;
                end
            end
            ock_pkg::CMD_SELECT_UP:
            begin
                if (state_reg == ST_SELECT && press_reg < cfg.hold_ticks)
                begin
                    // short press: cycle the mode
                    case (mode_reg)
                        ock_pkg::MODE_BAKE:
                        begin
                            set_temp_next = cfg.bake_default_temp;
                            mode_next     = ock_pkg::MODE_TOAST;
                        end
                        ock_pkg::MODE_TOAST:
                        begin
                            mode_next = ock_pkg::MODE_BROIL;
                        end
                        default:
                        begin
                            set_temp_next = cfg.bake_default_temp;
                            mode_next     = ock_pkg::MODE_BAKE;
                        end
                    endcase
                    set_min_next  = 3'd0;
                    set_sec_next  = 6'd1;
                    temp_sel_next = 1'b0;
                    state_next    = ST_SETUP;
                end
            end
            ock_pkg::CMD_START_DOWN:
            begin
                if (state_reg == ST_SETUP)
                begin
                    if (set_total_secs != 9'd0)
                    begin
                        total_next   = {set_total_secs[7:0], 1'b0};
                        remain_next  = {set_total_secs[7:0], 1'b0};
                        heating_next = 1'b1;
                        led_next     = 8'hFF;
                        state_next   = ST_COOK;
                    end
                end
                else if (state_reg == ST_COOK)
                begin
                    press_next = 5'd0;
                    state_next = ST_CANCEL;
                end
            end
            ock_pkg::CMD_START_UP:
            begin
                if (state_reg == ST_CANCEL)
                begin
                    state_next = ST_COOK;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SETUP;
            mode_reg     <= ock_pkg::MODE_BAKE;
            temp_sel_reg <= 1'b0;
            set_min_reg  <= 3'd0;
            set_sec_reg  <= 6'd0;
            set_temp_reg <= ock_pkg::BAKE_TEMP_RESET;
            total_reg    <= 9'd0;
            remain_reg   <= 9'd0;
            press_reg    <= 5'd0;
            heating_reg  <= 1'b0;
            led_reg      <= 8'h00;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            temp_sel_reg <= temp_sel_next;
            set_min_reg  <= set_min_next;
            set_sec_reg  <= set_sec_next;
            set_temp_reg <= set_temp_next;
            total_reg    <= total_next;
            remain_reg   <= remain_next;
            press_reg    <= press_next;
            heating_reg  <= heating_next;
            led_reg      <= led_next;
        end
    end

    always_comb
    begin
        unique case (state_next)
            ST_SETUP:  phase = ock_pkg::PHASE_SETUP;
            ST_COOK:   phase = ock_pkg::PHASE_COOK;
            ST_CANCEL: phase = ock_pkg::PHASE_CANCEL;
            ST_SELECT: phase = ock_pkg::PHASE_SELECT;
            default:   phase = ock_pkg::PHASE_SETUP;
        endcase
    end

    // result reflects the state after this event
    always_comb
    begin
        result.phase          = phase;
        result.mode           = mode_next;
        result.adjusting_temp = temp_sel_next;
        result.minutes        = set_min_next;
        result.seconds        = set_sec_next;
        result.temperature    = (mode_next == ock_pkg::MODE_BROIL) ? cfg.broil_temp
                                                                   : set_temp_next;
        result.top_heater     = heating_next && (mode_next != ock_pkg::MODE_TOAST);
        result.bottom_heater  = heating_next && (mode_next != ock_pkg::MODE_BROIL);
        result.leds           = led_next;
    end

`ifndef ASSERT_OFF
    a_heat_phase: assert property (@(posedge clk) disable iff (!rst_n)
        heating_reg |-> (state_reg == ST_COOK || state_reg == ST_CANCEL))
        else $error("heater on outside cooking");

    a_led_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !heating_reg |-> (led_reg == 8'h00))
        else $error("progress bar lit while idle");

    a_remain_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= total_reg)
        else $error("remaining time exceeds total");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (set_sec_reg <= 6'd59) && (set_min_reg <= 3'd4))
        else $error("set time out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/core/oven_cook_controller_core.sv
// ----------------------------------------------------------------------------
// oven_cook_controller_core
// Event driven oven controller: mode, time, temperature, countdown, heaters.
// ----------------------------------------------------------------------------
// Pipeline: an accepted event goes to the input register, then its result
//   beat to the result register, which drives the result stream.
// Throughput: one event per cycle unless the output stalls, set by the single
//   pass of event logic between the input register and the result register.
// Reset: rst_n is asynchronous, active low; clears the pipeline and loads
//   setup phase, bake mode, zero time, 350 degrees and default config.
`default_nettype none

module oven_cook_controller_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // event stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] knob_value
    input  wire logic [2:0]  s_tuser,   // [2:0] cmd

    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,   // [1:0] phase, [3:2] mode, [4] adjusting_temp,
                                        // [7:5] minutes, [13:8] seconds,
                                        // [23:14] temperature, [24] top_heater,
                                        // [25] bottom_heater, [33:26] leds, rest zero

    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    ock_pkg::cfg_t    cfg;
    ock_pkg::item_t   item_reg;
    logic             in_valid_reg;
    ock_pkg::result_t result;
    ock_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             step;

    // Output stage moves when empty or when the consumer takes the beat.
    assign advance  = !out_valid_reg || m_tready;
    // Input stage takes a beat when empty or when its item moves on.
    assign s_tready = !in_valid_reg || advance;
    // An item is applied to the controller state as it moves to the output.
    assign step     = in_valid_reg && advance;

    ock_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ock_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register: payload, hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.cmd        <= s_tuser;
            item_reg.knob_value <= s_tdata;
        end
    end

    // result register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register: payload, capture the post-event view
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000,
                       out_reg.leds,
                       out_reg.bottom_heater,
                       out_reg.top_heater,
                       out_reg.temperature,
                       out_reg.seconds,
                       out_reg.minutes,
                       out_reg.adjusting_temp,
                       out_reg.mode,
                       out_reg.phase};

endmodule

`default_nettype wire

// File: dv/oven_cook_controller_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oven_cook_controller_core_tb
// Self-checking bench for the oven cook controller core. Streams button,
// knob and timer events into the core and predicts the status beat of each
// one in a scoreboard that keeps its own copy of the controller. Every
// status beat is compared field by field. Several register settings are run,
// the extremes among them, with random bursts on the event side and random
// stalls on the status side.
// ----------------------------------------------------------------------------

module oven_cook_controller_core_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    // Generous bound: a few thousand events at worst-case gaps and stalls
    // stay far below this.
    localparam int CYCLE_LIMIT  = 600000;
    // The core holds an accepted event in its input register, then the status beat
    // in its result register; settle before a register write and the final verdict.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 100;

    // The event code beyond the defined ones; the core must ignore it.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Receiver stall styles
    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_MOSTLY = 2;
    localparam int READY_SPARSE = 3;

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of the controller and the status beats it
    // predicts, oldest first.
    // ------------------------------------------------------------------------
    class cook_scoreboard;
        logic [4:0] hold_limit;
        logic [9:0] bake_temp;
        logic [9:0] broil_temp;

        logic [1:0] phase;
        logic [1:0] mode;
        logic       temp_sel;
        logic [2:0] set_min;
        logic [5:0] set_sec;
        logic [9:0] set_temp;
        logic [8:0] total_halves;
        logic [8:0] left_halves;
        logic [4:0] presses;
        logic       heating;
        logic [7:0] bar;

        ock_pkg::result_t expected_status[$];
        int               mismatches;

        function new();
            hold_limit   = ock_pkg::HOLD_TICKS_RESET;
            bake_temp    = ock_pkg::BAKE_TEMP_RESET;
            broil_temp   = ock_pkg::BROIL_TEMP_RESET;
            phase        = ock_pkg::PHASE_SETUP;
            mode         = ock_pkg::MODE_BAKE;
            temp_sel     = 1'b0;
            set_min      = '0;
            set_sec      = '0;
            set_temp     = ock_pkg::BAKE_TEMP_RESET;
            total_halves = '0;
            left_halves  = '0;
            presses      = '0;
            heating      = 1'b0;
            bar          = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [9:0] value);
            case (index)
                ock_pkg::CFG_HOLD_TICKS: hold_limit = value[4:0];
                ock_pkg::CFG_BAKE_TEMP:  bake_temp  = value;
                ock_pkg::CFG_BROIL_TEMP: broil_temp = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void load_time(int secs);
            set_min = 3'(secs / 60);
            set_sec = 6'(secs % 60);
        endfunction

        // k lit bits, k the least of 1..8 with 8*r <= k*t
        function logic [7:0] progress_bar(logic [8:0] r, logic [8:0] t);
            int k;
            if (r == 0 || t == 0)
                return 8'h00;
            k = 1;
            while (k < 8 && 8 * int'(r) > k * int'(t))
                k++;
            return 8'((1 << k) - 1);
        endfunction

        function void return_to_setup();
            heating  = 1'b0;
            bar      = 8'h00;
            temp_sel = 1'b0;
            if (mode == ock_pkg::MODE_BAKE)
                set_temp = bake_temp;
            phase = ock_pkg::PHASE_SETUP;
        endfunction

        // Apply one accepted event and queue the status it produces.
        function void advance_oven(logic [2:0] cmd, logic [7:0] knob);
            ock_pkg::result_t status;
            int               halves;
            case (cmd)
                ock_pkg::CMD_HALF_TICK:
                begin
                    if (heating && left_halves > 0)
                    begin
                        left_halves--;
                        if (!left_halves[0])
                            load_time(int'(left_halves) / 2);
                        if (left_halves == 0)
                            return_to_setup();
                        else
                            bar = progress_bar(left_halves, total_halves);
                    end
                end
                ock_pkg::CMD_PRESS_TICK:
                begin
                    if (presses < ock_pkg::PRESS_MAX)
                        presses++;
                    if (presses >= hold_limit)
                    begin
                        if (phase == ock_pkg::PHASE_SELECT)
                        begin
                            if (mode == ock_pkg::MODE_BAKE)
                                temp_sel = ~temp_sel;
                            phase = ock_pkg::PHASE_SETUP;
                        end
                        else if (phase == ock_pkg::PHASE_CANCEL)
                            return_to_setup();
                    end
                end
                ock_pkg::CMD_KNOB:
                begin
                    if (phase == ock_pkg::PHASE_SETUP)
                    begin
                        if (temp_sel)
                            set_temp = 10'(knob) + ock_pkg::KNOB_OFFSET;
                        else
                            load_time(int'(knob));
                    end
                end
                ock_pkg::CMD_SELECT_DOWN:
                begin
                    if (phase == ock_pkg::PHASE_SETUP)
                    begin
                        presses = '0;
                        phase   = ock_pkg::PHASE_SELECT;
                    end
                end
                ock_pkg::CMD_SELECT_UP:
                begin
                    if (phase == ock_pkg::PHASE_SELECT && presses < hold_limit)
                    begin
                        if (mode == ock_pkg::MODE_BAKE)
                        begin
                            set_temp = bake_temp;
                            mode     = ock_pkg::MODE_TOAST;
                        end
                        else if (mode == ock_pkg::MODE_TOAST)
                            mode = ock_pkg::MODE_BROIL;
                        else
                        begin
                            set_temp = bake_temp;
                            mode     = ock_pkg::MODE_BAKE;
                        end
                        set_min  = 3'd0;
                        set_sec  = 6'd1;
                        temp_sel = 1'b0;
                        phase    = ock_pkg::PHASE_SETUP;
                    end
                end
                ock_pkg::CMD_START_DOWN:
                begin
                    if (phase == ock_pkg::PHASE_SETUP)
                    begin
                        halves = 2 * (int'(set_min) * 60 + int'(set_sec));
                        if (halves != 0)
                        begin
                            total_halves = 9'(halves);
                            left_halves  = total_halves;
                            heating      = 1'b1;
                            bar          = 8'hFF;
                            phase        = ock_pkg::PHASE_COOK;
                        end
                    end
                    else if (phase == ock_pkg::PHASE_COOK)
                    begin
                        presses = '0;
                        phase   = ock_pkg::PHASE_CANCEL;
                    end
                end
                ock_pkg::CMD_START_UP:
                begin
                    if (phase == ock_pkg::PHASE_CANCEL)
                        phase = ock_pkg::PHASE_COOK;
                end
                default: ;
            endcase

            status.phase          = phase;
            status.mode           = mode;
            status.adjusting_temp = temp_sel;
            status.minutes        = set_min;
            status.seconds        = set_sec;
            status.temperature    = (mode == ock_pkg::MODE_BROIL) ? broil_temp : set_temp;
            status.top_heater     = heating && mode != ock_pkg::MODE_TOAST;
            status.bottom_heater  = heating && mode != ock_pkg::MODE_BROIL;
            status.leds           = bar;
            expected_status.push_back(status);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        task field_check(string name, int got, int want);
            if (got != want)
                report_mismatch(name, got, want);
        endtask

        // Compare one status beat with the oldest prediction.
        task check_result(logic [39:0] beat);
            ock_pkg::result_t want;
            if (expected_status.size() == 0)
            begin
                report_mismatch("status beat with nothing pending", int'(beat[33:0]), 0);
                return;
            end
            want = expected_status.pop_front();
            field_check("phase",          beat[1:0],   want.phase);
            field_check("mode",           beat[3:2],   want.mode);
            field_check("adjusting_temp", beat[4],     want.adjusting_temp);
            field_check("minutes",        beat[7:5],   want.minutes);
            field_check("seconds",        beat[13:8],  want.seconds);
            field_check("temperature",    beat[23:14], want.temperature);
            field_check("top_heater",     beat[24],    want.top_heater);
            field_check("bottom_heater",  beat[25],    want.bottom_heater);
            field_check("leds",           beat[33:26], want.leds);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] knob_value
    logic [2:0]  s_tuser   = '0;   // [2:0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [1:0] phase, [3:2] mode, [4] adjusting_temp,
                                   // [7:5] minutes, [13:8] seconds, [23:14] temperature,
                                   // [24] top_heater, [25] bottom_heater, [33:26] leds
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data  = '0;

    cook_scoreboard sb;
    int             items_sent  = 0;
    int             burst_left  = 0;
    int             cycle_count = 0;
    int             stall_style = READY_ALWAYS;
    int             stall_run   = 0;

    always #CLK_HALF clk = ~clk;

    oven_cook_controller_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Watchdog: end the run if the core hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("oven_cook_controller_core regression: fail");
            $finish;
        end
    end

    // Receiver: pick a stall style for a random run of cycles, then another.
    // The always-ready style gives stretches with no backpressure at all.
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_style = $urandom_range(READY_ALWAYS, READY_SPARSE);
            stall_run   = $urandom_range(4, 40);
        end
        stall_run--;
        case (stall_style)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            default:      m_tready <= ((stall_run % 8) < 2);  // long stalls
        endcase
    end

    // Status monitor: sample at the rising edge, check every accepted beat.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Event driver
    // ------------------------------------------------------------------------

    // Drive one event beat and hold it until accepted. Bursts of random
    // length are separated by random gaps; valid stays high inside a burst.
    task automatic send_event(logic [2:0] cmd, logic [7:0] knob);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= knob;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.advance_oven(cmd, knob);
        items_sent++;
        burst_left--;
    endtask

    // Event whose knob field is don't-care: fill it with noise.
    task automatic send_cmd(logic [2:0] cmd);
        send_event(cmd, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_press_ticks(int count);
        repeat (count) send_cmd(ock_pkg::CMD_PRESS_TICK);
    endtask

    // Drop valid and hold until every predicted status has come back,
    // then let the pipeline settle.
    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all three registers on back-to-back cycles; only while idle.
    task automatic write_settings(logic [4:0] press_ticks, logic [9:0] bake,
                                  logic [9:0] broil);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ock_pkg::CFG_HOLD_TICKS;
        cfg_data  <= {5'd0, press_ticks};
        sb.write_reg(ock_pkg::CFG_HOLD_TICKS, {5'd0, press_ticks});
        @(negedge clk);
        cfg_index <= ock_pkg::CFG_BAKE_TEMP;
        cfg_data  <= bake;
        sb.write_reg(ock_pkg::CFG_BAKE_TEMP, bake);
        @(negedge clk);
        cfg_index <= ock_pkg::CFG_BROIL_TEMP;
        cfg_data  <= broil;
        sb.write_reg(ock_pkg::CFG_BROIL_TEMP, broil);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random phase: mostly well-formed button and cook sequences with random
    // content, the rest single noise events in any phase.
    task automatic run_random_phase(int target);
        int start;
        int kind;
        int secs;
        int step;
        int guard;
        start = items_sent;
        while (items_sent - start < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 1)
                send_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            else if (kind == 2)
                send_event(ock_pkg::CMD_KNOB, 8'($urandom_range(0, 255)));
            else if (kind <= 4)
            begin
                // short press: stay below the threshold
                send_cmd(ock_pkg::CMD_SELECT_DOWN);
                if (sb.hold_limit > 1)
                    send_press_ticks($urandom_range(0, int'(sb.hold_limit) - 1));
                send_cmd(ock_pkg::CMD_SELECT_UP);
            end
            else if (kind == 5)
            begin
                // long press: reach or pass the threshold, then release
                send_cmd(ock_pkg::CMD_SELECT_DOWN);
                send_press_ticks(int'(sb.hold_limit) + $urandom_range(0, 2));
                send_cmd(ock_pkg::CMD_SELECT_UP);
            end
            else
            begin
                // set a time (mostly short), start, count down with cancel tries
                secs = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 12);
                send_event(ock_pkg::CMD_KNOB, 8'(secs));
                send_cmd(ock_pkg::CMD_START_DOWN);
                guard = 0;
                while (sb.heating && guard < 800)
                begin
                    guard++;
                    step = $urandom_range(0, 11);
                    if (step < 8)
                        send_cmd(ock_pkg::CMD_HALF_TICK);
                    else if (step == 8)
                    begin
                        // held too briefly: cooking resumes
                        send_cmd(ock_pkg::CMD_START_DOWN);
                        if (sb.hold_limit > 1)
                            send_press_ticks($urandom_range(0, int'(sb.hold_limit) - 1));
                        send_cmd(ock_pkg::CMD_START_UP);
                    end
                    else if (step == 9)
                    begin
                        // held past the threshold: cancel
                        send_cmd(ock_pkg::CMD_START_DOWN);
                        send_press_ticks(int'(sb.hold_limit) + $urandom_range(0, 1));
                    end
                    else
                        send_event(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset register values.
        send_event(ock_pkg::CMD_KNOB, 8'd0);      // time 0:00
        send_cmd(ock_pkg::CMD_START_DOWN);        // start with zero time: ignored
        send_event(ock_pkg::CMD_KNOB, 8'd255);    // largest knob: 4:15
        send_cmd(ock_pkg::CMD_SELECT_DOWN);
        send_cmd(ock_pkg::CMD_SELECT_UP);         // bake -> toast, time 0:01
        send_cmd(ock_pkg::CMD_SELECT_DOWN);
        send_cmd(ock_pkg::CMD_SELECT_UP);         // toast -> broil
        send_cmd(ock_pkg::CMD_SELECT_DOWN);
        send_cmd(ock_pkg::CMD_SELECT_UP);         // broil -> bake, bake temp reloaded
        send_cmd(ock_pkg::CMD_SELECT_DOWN);
        send_press_ticks(int'(ock_pkg::HOLD_TICKS_RESET));  // long press: adjust temperature
        send_event(ock_pkg::CMD_KNOB, 8'd255);    // hottest: 555
        send_event(ock_pkg::CMD_KNOB, 8'd0);      // coolest: 300
        send_cmd(ock_pkg::CMD_SELECT_UP);         // release outside select: ignored
        send_cmd(ock_pkg::CMD_SELECT_DOWN);
        send_cmd(ock_pkg::CMD_SELECT_UP);         // short press back to time, toast
        send_cmd(ock_pkg::CMD_START_DOWN);        // cook one second
        send_cmd(ock_pkg::CMD_START_DOWN);        // cancel pending
        send_cmd(ock_pkg::CMD_START_UP);          // released early: cooking again
        send_cmd(ock_pkg::CMD_HALF_TICK);
        send_cmd(ock_pkg::CMD_HALF_TICK);         // countdown ends
        send_cmd(ock_pkg::CMD_HALF_TICK);         // tick while idle: ignored
        send_event(CMD_UNUSED, 8'hA5);            // undefined code: ignored
        send_cmd(ock_pkg::CMD_START_UP);          // wrong phase: ignored

        // Register settings, the extremes first; drain before each write.
        hold_until_drained();
        write_settings(5'd1, 10'd300, 10'd555);
        run_random_phase(PHASE_ITEMS);

        hold_until_drained();
        write_settings(5'd31, 10'd555, 10'd300);
        run_random_phase(PHASE_ITEMS);

        // zero threshold and temperatures outside the knob range
        hold_until_drained();
        write_settings(5'd0, 10'd0, 10'd1023);
        run_random_phase(PHASE_ITEMS);

        repeat (2)
        begin
            hold_until_drained();
            write_settings(5'($urandom_range(0, 31)), 10'($urandom_range(300, 555)),
                           10'($urandom_range(0, 1023)));
            run_random_phase(PHASE_ITEMS);
        end

        hold_until_drained();
        write_settings(ock_pkg::HOLD_TICKS_RESET, ock_pkg::BAKE_TEMP_RESET,
                       ock_pkg::BROIL_TEMP_RESET);
        run_random_phase(PHASE_ITEMS);

        // Wait out the last beats plus the pipeline depth.
        hold_until_drained();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("oven_cook_controller_core regression: pass");
        else
            $display("oven_cook_controller_core regression: fail");
        $finish;
    end

endmodule
